// File: rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and codes of the positional list engine.
// ----------------------------------------------------------------------------
package plm_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic [4:0]         count;
  } rsp_t;

endpackage

// File: rtl/plm_mem.sv
// ----------------------------------------------------------------------------
// plm_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plm_mem #(
  parameter int  CAPACITY = 16,
  localparam int AW       = $clog2(CAPACITY)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic signed [31:0]  rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [31:0]  wr_data
);

  logic signed [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/plm_ctrl.sv
// ----------------------------------------------------------------------------
// plm_ctrl
// Command decode and shift sequencer: moves entries one per cycle through
// the entry store, then reports the result of the request.
// ----------------------------------------------------------------------------
module plm_ctrl #(
  parameter int  CAPACITY = 16,
  localparam int AW       = $clog2(CAPACITY),
  localparam int LW       = $clog2(CAPACITY + 1),
  localparam int CW       = (LW > 5) ? LW : 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  plm_pkg::req_t       req,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_take,
  output plm_pkg::rsp_t       res,
  output logic [LW-1:0]       length,
  output logic                mem_rd_en,
  output logic [AW-1:0]       mem_rd_addr,
  input  logic signed [31:0]  mem_rd_data,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output logic signed [31:0]  mem_wr_data
);

  plm_pkg::state_t    state, state_next;
  logic [LW-1:0]      length_next;
  logic               pend_valid, pend_valid_next;
  logic [AW-1:0]      pend_addr, pend_addr_next;
  logic               pend_first, pend_first_next;
  logic               first, first_next;
  logic               ins, ins_next;
  logic [AW-1:0]      tp, tp_next;
  logic [AW-1:0]      rptr, rptr_next;
  logic [LW-1:0]      cnt, cnt_next;
  logic signed [31:0] vval, vval_next;
  plm_pkg::status_t   status, status_next;
  logic signed [31:0] removed, removed_next;

  logic               dec_mem, dec_ins;
  plm_pkg::status_t   dec_st;
  logic [AW-1:0]      dec_tp;
  logic [CW-1:0]      pos_x, len_x;
  logic               full, empty;

  assign pos_x = CW'(req.position);
  assign len_x = CW'(length);
  assign full  = (len_x == CW'(CAPACITY));
  assign empty = (length == '0);

  always_comb begin
    dec_mem = 1'b0;
    dec_ins = 1'b0;
    dec_st  = plm_pkg::ST_DONE;
    dec_tp  = '0;
    unique case (req.op)
      plm_pkg::OP_INS_FRONT: begin
        if (full) dec_st = plm_pkg::ST_FULL;
        else begin
          dec_mem = 1'b1;
          dec_ins = 1'b1;
        end
      end
      plm_pkg::OP_INS_BACK: begin
        if (full) dec_st = plm_pkg::ST_FULL;
        else begin
          dec_mem = 1'b1;
          dec_ins = 1'b1;
          dec_tp  = AW'(length);
        end
      end
      plm_pkg::OP_INS_AT: begin
        if (pos_x == '0) begin
          if (full) dec_st = plm_pkg::ST_FULL;
          else begin
            dec_mem = 1'b1;
            dec_ins = 1'b1;
          end
        end else if (empty) dec_st = plm_pkg::ST_EMPTY;
        else if (pos_x > len_x) dec_st = plm_pkg::ST_RANGE;
        else if (full) dec_st = plm_pkg::ST_FULL;
        else begin
          dec_mem = 1'b1;
          dec_ins = 1'b1;
          dec_tp  = AW'(req.position);
        end
      end
      plm_pkg::OP_REM_FRONT: begin
        if (empty) dec_st = plm_pkg::ST_EMPTY;
        else dec_mem = 1'b1;
      end
      plm_pkg::OP_REM_BACK: begin
        if (empty) dec_st = plm_pkg::ST_EMPTY;
        else begin
          dec_mem = 1'b1;
          dec_tp  = AW'(length - LW'(1));
        end
      end
      plm_pkg::OP_REM_AT: begin
        if (empty) dec_st = plm_pkg::ST_EMPTY;
        else if (pos_x >= len_x) dec_st = plm_pkg::ST_RANGE;
        else begin
          dec_mem = 1'b1;
          dec_tp  = AW'(req.position);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next      = state;
    length_next     = length;
    pend_valid_next = pend_valid;
    pend_addr_next  = pend_addr;
    pend_first_next = pend_first;
    first_next      = first;
    ins_next        = ins;
    tp_next         = tp;
    rptr_next       = rptr;
    cnt_next        = cnt;
    vval_next       = vval;
    status_next     = status;
    removed_next    = removed;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = rptr;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = pend_addr;
    mem_wr_data     = mem_rd_data;
    unique case (state)
      plm_pkg::S_IDLE: begin
        if (start) begin
          status_next     = dec_st;
          removed_next    = '0;
          ins_next        = dec_ins;
          tp_next         = dec_tp;
          vval_next       = req.item_value;
          cnt_next        = length - LW'(dec_tp);
          rptr_next       = dec_ins ? AW'(length - LW'(1)) : dec_tp;
          first_next      = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = dec_mem ? plm_pkg::S_RUN : plm_pkg::S_DONE;
        end
      end
      plm_pkg::S_RUN: begin
        // data read last cycle: moved one place, or the removed entry
        if (pend_valid) begin
          if (!ins && pend_first) removed_next = mem_rd_data;
          else mem_wr_en = 1'b1;
        end
        if (cnt != '0) begin
          mem_rd_en       = 1'b1;
          pend_valid_next = 1'b1;
          pend_addr_next  = ins ? rptr + AW'(1) : rptr - AW'(1);
          pend_first_next = first;
          first_next      = 1'b0;
          rptr_next       = ins ? rptr - AW'(1) : rptr + AW'(1);
          cnt_next        = cnt - LW'(1);
        end else begin
          pend_valid_next = 1'b0;
          if (!pend_valid) begin
            if (ins) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = tp;
              mem_wr_data = vval;
            end
            length_next = ins ? length + LW'(1) : length - LW'(1);
            state_next  = plm_pkg::S_DONE;
          end
        end
      end
      plm_pkg::S_DONE: begin
        if (res_take) state_next = plm_pkg::S_IDLE;
      end
      default: state_next = plm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= plm_pkg::S_IDLE;
      length     <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      length     <= length_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr  <= pend_addr_next;
    pend_first <= pend_first_next;
    first      <= first_next;
    ins        <= ins_next;
    tp         <= tp_next;
    rptr       <= rptr_next;
    cnt        <= cnt_next;
    vval       <= vval_next;
    status     <= status_next;
    removed    <= removed_next;
  end

  assign idle      = (state == plm_pkg::S_IDLE);
  assign res_valid = (state == plm_pkg::S_DONE);

  always_comb begin
    res.status        = status;
    res.removed_value = removed;
    res.count         = 5'(length);
  end

endmodule

// File: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with insert and remove at the
// front, the back or a given position.
// ----------------------------------------------------------------------------
// One request is worked at a time; each gives exactly one response with
// status, removed value and the entry count after the request (modulo 32).
// A request that fails or does nothing goes straight to its response; an insert
// at the back writes its value and then responds. Any other insert or remove at
// position p first moves the entries behind p: the entry memory has one read and
// one write port, so the entries behind p move one per cycle. The next request
// is taken once the response has passed into the output register, so a request
// occupies the engine until then.
// The response sits in an output register, so the next request is taken
// while an earlier response is still stalled.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  plm_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output plm_pkg::rsp_t rsp_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic               idle, res_valid, res_take, start;
  plm_pkg::rsp_t      res;
  logic [LW-1:0]      length;
  logic               mem_rd_en, mem_wr_en;
  logic [AW-1:0]      mem_rd_addr, mem_wr_addr;
  logic signed [31:0] mem_rd_data, mem_wr_data;

  assign req_stall = !idle;
  assign start     = req_valid && idle;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  plm_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req_data),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .length      (length),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  plm_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp_data <= res;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(length) <= 32'(CAPACITY))
    else $error("list length above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while previous one in progress");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status == plm_pkg::ST_FULL) |-> rsp_data.count == 5'(CAPACITY))
    else $error("full reported with list not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != plm_pkg::ST_DONE) |-> rsp_data.removed_value == '0)
    else $error("failed request returned a value");

endmodule

// File: test/positional_list_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the positional list engine.
// ----------------------------------------------------------------------------
// Requests are queued up front: a short directed run over the empty, range,
// spare-code and extreme-value cases, then random fill, drain and mixed
// sequences that sweep the list between empty and full, with some noise.
// Each accepted request is applied to a behavioural copy of the list and the
// answer it gives is queued; responses are checked field by field in order.
// Both sides wait at random, and once the response side holds off long
// enough for the engine to back up and stall its requests.
// ----------------------------------------------------------------------------
module positional_list_engine_test;

  localparam int LIST_DEPTH  = 16;
  localparam int ITEM_COUNT  = 2000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum {FILL_UP, DRAIN_DOWN, MIXED} sweep_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  plm_pkg::req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  plm_pkg::rsp_t rsp_data;

  plm_pkg::req_t commands_to_send[$];
  plm_pkg::rsp_t answers_due[$];

  logic signed [31:0] list_mem [LIST_DEPTH];
  int list_len;
  int longest;
  int gen_len;

  bit req_fire;
  bit rsp_fire;
  bit hold_off;
  int send_wait;
  int send_calm;
  int recv_wait;
  int recv_calm;

  int cycle_count;
  int commands_taken;
  int answers_checked;
  int errors;
  int pressure_stalls;
  int status_seen [4];

  positional_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Draws a random wait, with occasional runs of back-to-back traffic.
  function automatic int draw_wait(inout int calm);
    int w;
    if (calm > 0) begin
      calm--;
      w = 0;
    end else begin
      w = $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0) calm = $urandom_range(20, 80);
    end
    return w;
  endfunction

  function automatic plm_pkg::status_t list_insert(int p, logic signed [31:0] v);
    if (list_len >= LIST_DEPTH) return plm_pkg::ST_FULL;
    for (int k = list_len; k > p; k--) list_mem[k] = list_mem[k - 1];
    list_mem[p] = v;
    list_len++;
    if (list_len > longest) longest = list_len;
    return plm_pkg::ST_DONE;
  endfunction

  function automatic logic signed [31:0] list_remove(int p);
    logic signed [31:0] v;
    v = list_mem[p];
    for (int k = p; k < list_len - 1; k++) list_mem[k] = list_mem[k + 1];
    list_len--;
    return v;
  endfunction

  function automatic plm_pkg::rsp_t run_list_command(plm_pkg::req_t c);
    plm_pkg::rsp_t a;
    a.status = plm_pkg::ST_DONE;
    a.removed_value = '0;
    case (c.op)
      plm_pkg::OP_INS_FRONT: a.status = list_insert(0, c.item_value);
      plm_pkg::OP_INS_BACK:  a.status = list_insert(list_len, c.item_value);
      plm_pkg::OP_INS_AT: begin
        if (c.position == 0) a.status = list_insert(0, c.item_value);
        else if (list_len == 0) a.status = plm_pkg::ST_EMPTY;
        else if (int'(c.position) > list_len) a.status = plm_pkg::ST_RANGE;
        else a.status = list_insert(int'(c.position), c.item_value);
      end
      plm_pkg::OP_REM_FRONT: begin
        if (list_len == 0) a.status = plm_pkg::ST_EMPTY;
        else a.removed_value = list_remove(0);
      end
      plm_pkg::OP_REM_BACK: begin
        if (list_len == 0) a.status = plm_pkg::ST_EMPTY;
        else a.removed_value = list_remove(list_len - 1);
      end
      plm_pkg::OP_REM_AT: begin
        if (list_len == 0) a.status = plm_pkg::ST_EMPTY;
        else if (int'(c.position) >= list_len) a.status = plm_pkg::ST_RANGE;
        else a.removed_value = list_remove(int'(c.position));
      end
      default: ;
    endcase
    a.count = 5'(list_len);
    return a;
  endfunction

  // Queues a request and tracks the list length it will leave behind.
  task automatic queue_command(logic [2:0] op, int pos, logic signed [31:0] v);
    plm_pkg::req_t c;
    c.op = op;
    c.position = 5'(pos);
    c.item_value = v;
    commands_to_send.push_back(c);
    case (op)
      plm_pkg::OP_INS_FRONT, plm_pkg::OP_INS_BACK: if (gen_len < LIST_DEPTH) gen_len++;
      plm_pkg::OP_INS_AT: begin
        if (pos == 0 || (gen_len != 0 && pos <= gen_len))
          if (gen_len < LIST_DEPTH) gen_len++;
      end
      plm_pkg::OP_REM_FRONT, plm_pkg::OP_REM_BACK: if (gen_len > 0) gen_len--;
      plm_pkg::OP_REM_AT: if (gen_len > 0 && pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0;
      3:       return -32'sh1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_commands();
    sweep_t sweep;
    int kind;
    sweep = FILL_UP;
    for (int i = 0; i < ITEM_COUNT; i++) begin
      if (sweep == FILL_UP && gen_len == LIST_DEPTH && $urandom_range(0, 3) == 0)
        sweep = DRAIN_DOWN;
      else if (sweep == DRAIN_DOWN && gen_len == 0 && $urandom_range(0, 3) == 0)
        sweep = FILL_UP;
      else if ($urandom_range(0, 63) == 0)
        sweep = sweep_t'($urandom_range(0, 2));
      kind = $urandom_range(0, 5);
      if ($urandom_range(0, 9) == 0) begin
        queue_command(3'($urandom_range(0, 7)), $urandom_range(0, 31), random_value());
      end else if (sweep == FILL_UP && kind < 5 || sweep == DRAIN_DOWN && kind == 5) begin
        case (kind % 3)
          0: queue_command(plm_pkg::OP_INS_FRONT, $urandom_range(0, 31), random_value());
          1: queue_command(plm_pkg::OP_INS_BACK, $urandom_range(0, 31), random_value());
          default: queue_command(plm_pkg::OP_INS_AT, $urandom_range(0, gen_len),
                                 random_value());
        endcase
      end else if (sweep != MIXED) begin
        case (kind % 3)
          0: queue_command(plm_pkg::OP_REM_FRONT, $urandom_range(0, 31), random_value());
          1: queue_command(plm_pkg::OP_REM_BACK, $urandom_range(0, 31), random_value());
          default: queue_command(plm_pkg::OP_REM_AT,
                                 $urandom_range(0, gen_len > 0 ? gen_len - 1 : 0),
                                 random_value());
        endcase
      end else begin
        case (kind)
          plm_pkg::OP_INS_AT: queue_command(plm_pkg::OP_INS_AT, $urandom_range(0, gen_len),
                                            random_value());
          plm_pkg::OP_REM_AT: queue_command(plm_pkg::OP_REM_AT,
                                            $urandom_range(0, gen_len > 0 ? gen_len - 1 : 0),
                                            random_value());
          default:   queue_command(3'(kind), $urandom_range(0, 31), random_value());
        endcase
      end
    end
  endtask

  // Request side: a new request is offered only once the last one is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_fire) begin
        if (send_wait > 0) begin
          send_wait--;
          req_valid <= 1'b0;
        end else if (commands_to_send.size() != 0) begin
          req_data <= commands_to_send.pop_front();
          req_valid <= 1'b1;
          send_wait = draw_wait(send_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response side
  always @(negedge clk) begin
    if (rsp_fire) recv_wait = draw_wait(recv_calm);
    if (recv_wait > 0) begin
      recv_wait--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= hold_off;
    end
  end

  always @(posedge clk) begin
    plm_pkg::rsp_t want;
    req_fire <= !rst && req_valid && !req_stall;
    rsp_fire <= !rst && rsp_valid && !rsp_stall;
    if (!rst) begin
      cycle_count++;
      if (hold_off && req_stall) pressure_stalls++;
      if (req_valid && !req_stall) begin
        answers_due.push_back(run_list_command(req_data));
        commands_taken++;
      end
      if (rsp_valid && !rsp_stall) begin
        answers_checked++;
        status_seen[rsp_data.status]++;
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: response with none expected: status %0d removed %0d count %0d",
                   $time, rsp_data.status, rsp_data.removed_value, rsp_data.count);
        end else begin
          want = answers_due.pop_front();
          if (rsp_data.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     rsp_data.status);
          end
          if (rsp_data.removed_value !== want.removed_value) begin
            errors++;
            $display("%0t: removed_value expected %0d, got %0d", $time,
                     want.removed_value, rsp_data.removed_value);
          end
          if (rsp_data.count !== want.count) begin
            errors++;
            $display("%0t: count expected %0d, got %0d", $time, want.count,
                     rsp_data.count);
          end
        end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("%0t: timed out with %0d requests unsent, %0d answers outstanding",
                 $time, commands_to_send.size(), answers_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Long response hold-off so the engine backs up and stalls requests.
  initial begin
    hold_off = 1'b0;
    while (commands_taken < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    rsp_stall = 1'b0;
    list_len = 0;
    longest = 0;
    gen_len = 0;

    // empty list, spare codes
    queue_command(plm_pkg::OP_REM_FRONT, 0, 32'sh0);
    queue_command(plm_pkg::OP_REM_BACK, 31, -32'sh1);
    queue_command(plm_pkg::OP_REM_AT, 31, 32'sh0);
    queue_command(plm_pkg::OP_INS_AT, 31, 32'sh1234_5678);
    queue_command(OP_SPARE_LO, 0, 32'sh7fff_ffff);
    queue_command(OP_SPARE_HI, 31, -32'sh1);
    // extremes, edge positions
    queue_command(plm_pkg::OP_INS_AT, 0, 32'sh8000_0000);
    queue_command(plm_pkg::OP_INS_BACK, 0, 32'sh7fff_ffff);
    queue_command(plm_pkg::OP_INS_FRONT, 31, -32'sh1);
    queue_command(plm_pkg::OP_INS_AT, 3, 32'sh0);
    queue_command(plm_pkg::OP_INS_AT, 5, 32'sh5555_5555);
    queue_command(plm_pkg::OP_INS_AT, 2, 32'shaaaa_aaaa);
    queue_command(plm_pkg::OP_REM_AT, 5, 32'sh0);
    queue_command(plm_pkg::OP_REM_AT, 31, 32'sh0);
    queue_command(OP_SPARE_HI, 2, 32'sh0);
    queue_command(plm_pkg::OP_REM_AT, 2, 32'sh0);
    queue_command(plm_pkg::OP_REM_AT, 0, 32'sh0);
    queue_command(plm_pkg::OP_REM_BACK, 0, 32'sh0);
    queue_command(plm_pkg::OP_REM_FRONT, 0, 32'sh0);
    queue_command(plm_pkg::OP_REM_AT, 0, 32'sh0);
    queue_command(plm_pkg::OP_REM_BACK, 0, 32'sh0);
    queue_random_commands();

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (commands_to_send.size() != 0 || req_valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);

    $display("%0d requests, %0d responses; done %0d, empty %0d, range %0d, full %0d",
             commands_taken, answers_checked, status_seen[plm_pkg::ST_DONE],
             status_seen[plm_pkg::ST_EMPTY], status_seen[plm_pkg::ST_RANGE],
             status_seen[plm_pkg::ST_FULL]);
    $display("longest list %0d, request stalls under hold-off %0d, mismatches %0d",
             longest, pressure_stalls, errors);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
